// ===== rtl/mtw_pkg.sv =====
// shared types, constants and the log2 table for the mel triangle weight block
// no dependencies
package mtw_pkg;

  typedef enum logic [1:0] {
    REG_FREQ_STEP    = 2'd0,
    REG_LOW_FREQ     = 2'd1,
    REG_HIGH_FREQ    = 2'd2,
    REG_FILTER_COUNT = 2'd3
  } reg_idx_e;

  localparam int unsigned MEL_LANES = 3;
  localparam int unsigned MEL_W     = 20;
  localparam int unsigned FREQ_W    = 36;

  // 700 * 2^16, the offset that makes 1 + f/700 in Q16
  localparam logic [36:0] U_OFFSET  = 37'd45875200;
  // floor(2^35 / 175), quarter of the divide by 700
  localparam logic [27:0] RECIP_175 = 28'd196341362;
  localparam logic [25:0] MEL_SCALE = 26'd51194943;
  localparam logic [19:0] MEL_MAX   = 20'd1048575;

  typedef struct packed {
    logic [5:0] fi;
    logic [6:0] cnt;
    logic       idx_ok;
    logic       bin_ok;
  } query_t;

  typedef struct packed {
    logic             neg;
    logic [MEL_W-1:0] m;
    logic [MEL_W-1:0] ml;
    logic             idx_ok;
    logic             bin_ok;
  } cen_side_t;

  typedef struct packed {
    logic idx_ok;
    logic zero;
    logic full;
  } wt_side_t;

  // round(2^16 * log2(1 + k/16))
  function automatic logic [16:0] log2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mel_triangle_weight_top.sv =====
// top level of the mel triangle weight block: register file, query stages,
// centre and weight dividers; depends on mtw_pkg, mtw_mel and mtw_div
//
// usage
//   query channel: drive filter_index_i and bin_index_i with start high; the
//   transaction is taken at a rising edge where start is high and busy is
//   low. busy stays low, so a query can be issued on every cycle.
//   result channel: result_valid_o is high for one cycle with weight_o (Q1.16)
//   and index_valid_o; the receiver cannot stall and must take it then.
//   throughput: one query per cycle, results in query order. the result
//   passes through the chain mel conversion (9 stages), centre divider
//   (9 stages, 3 quotient bits each) and weight divider (8 stages, 2 bits).
//   configuration: apb-style port, registers at byte 0, 4, 8 and 12
//   (freq_step, low_freq, high_freq, filter_count); pready is always high.
//   band edge mels are worked out beside each query, so a query may follow
//   a register write at once. write registers only with no query in flight.
//   reset: asynchronous active low, clears the pipeline valid bits and loads
//   the default register values; nothing is in flight afterwards.
module mel_triangle_weight_top #(
  parameter int unsigned DFT_SIZE    = 512,
  parameter int unsigned MAX_FILTERS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  filter_index_i,
  input  logic [11:0] bin_index_i,
  output logic        result_valid_o,
  output logic [16:0] weight_o,
  output logic        index_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MW = mtw_pkg::MEL_W;
  localparam int unsigned L  = mtw_pkg::MEL_LANES;

  // register file
  logic [23:0] freq_step_q;
  logic [15:0] low_freq_q, high_freq_q;
  logic [6:0]  filter_count_q;
  logic        wr_en;
  mtw_pkg::reg_idx_e reg_idx;

  assign reg_idx = mtw_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_step_q    <= 24'd1024000;
      low_freq_q     <= 16'd0;
      high_freq_q    <= 16'd8000;
      filter_count_q <= 7'd24;
    end else if (wr_en) begin
      unique case (reg_idx)
        mtw_pkg::REG_FREQ_STEP:    freq_step_q    <= pwdata[23:0];
        mtw_pkg::REG_LOW_FREQ:     low_freq_q     <= pwdata[15:0];
        mtw_pkg::REG_HIGH_FREQ:    high_freq_q    <= pwdata[15:0];
        mtw_pkg::REG_FILTER_COUNT: filter_count_q <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mtw_pkg::REG_FREQ_STEP:    prdata = {8'b0, freq_step_q};
      mtw_pkg::REG_LOW_FREQ:     prdata = {16'b0, low_freq_q};
      mtw_pkg::REG_HIGH_FREQ:    prdata = {16'b0, high_freq_q};
      mtw_pkg::REG_FILTER_COUNT: prdata = {25'b0, filter_count_q};
    endcase
  end

  // stage 0: range checks and bin frequency
  logic                    s0_vld_q;
  mtw_pkg::query_t         s0_q_d, s0_q_q;
  logic [mtw_pkg::FREQ_W-1:0] fbin_d;
  logic [L-1:0][mtw_pkg::FREQ_W-1:0] s0_f_q;
  logic [6:0]              cnt_eff;

  assign cnt_eff = (filter_count_q < 7'(MAX_FILTERS)) ? filter_count_q : 7'(MAX_FILTERS);
  assign fbin_d  = 36'(bin_index_i) * 36'(freq_step_q);

  always_comb begin
    s0_q_d.fi     = filter_index_i;
    s0_q_d.cnt    = cnt_eff;
    s0_q_d.idx_ok = {1'b0, filter_index_i} < cnt_eff;
    s0_q_d.bin_ok = {1'b0, bin_index_i} < 13'(DFT_SIZE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q_q    <= s0_q_d;
    s0_f_q[0] <= fbin_d;
    s0_f_q[1] <= {4'b0, low_freq_q, 16'b0};
    s0_f_q[2] <= {4'b0, high_freq_q, 16'b0};
  end

  // mel of the bin (lane 0) and both band edges
  logic                     mel_vld;
  mtw_pkg::query_t          mel_side;
  logic [L-1:0][MW-1:0]     mel_val;

  mtw_mel u_mel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .side_i  (s0_q_q),
    .f_i     (s0_f_q),
    .valid_o (mel_vld),
    .side_o  (mel_side),
    .mel_o   (mel_val)
  );

  // stage 1: band span in mel
  logic            s1_vld_q;
  mtw_pkg::query_t s1_q_q;
  logic            s1_neg_d, s1_neg_q;
  logic [MW-1:0]   s1_mag_d, s1_mag_q, s1_m_q, s1_ml_q;

  assign s1_neg_d = mel_val[2] < mel_val[1];
  assign s1_mag_d = s1_neg_d ? (mel_val[1] - mel_val[2]) : (mel_val[2] - mel_val[1]);

  // stage 2: span times the centre positions of the three neighbours
  logic                 s2_vld_q;
  mtw_pkg::cen_side_t   s2_side_q;
  logic [7:0]           s2_den_d, s2_den_q;
  logic [L-1:0][26:0]   s2_prod_d, s2_prod_q;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      s2_prod_d[l] = 27'(s1_mag_q) * 27'({1'b0, s1_q_q.fi} + 7'(l));
    end
  end
  assign s2_den_d = 8'(s1_q_q.cnt) + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= mel_vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q_q           <= mel_side;
    s1_neg_q         <= s1_neg_d;
    s1_mag_q         <= s1_mag_d;
    s1_m_q           <= mel_val[0];
    s1_ml_q          <= mel_val[1];
    s2_side_q.neg    <= s1_neg_q;
    s2_side_q.m      <= s1_m_q;
    s2_side_q.ml     <= s1_ml_q;
    s2_side_q.idx_ok <= s1_q_q.idx_ok;
    s2_side_q.bin_ok <= s1_q_q.bin_ok;
    s2_den_q         <= s2_den_d;
    s2_prod_q        <= s2_prod_d;
  end

  // centre offsets, truncated towards zero through the magnitude
  logic                 cd_vld;
  mtw_pkg::cen_side_t   cd_side;
  logic [L-1:0][26:0]   cd_quot;

  mtw_div #(
    .LANES (L),
    .RW    (8),
    .QW    (27),
    .STEPS (3),
    .SW    ($bits(mtw_pkg::cen_side_t))
  ) u_cen_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .side_i  (s2_side_q),
    .den_i   (s2_den_q),
    .rem_i   ('0),
    .num_i   (s2_prod_q),
    .valid_o (cd_vld),
    .side_o  (cd_side),
    .quot_o  (cd_quot)
  );

  // stage 3: left, own and right centre
  logic           s3_vld_q, s3_idx_q, s3_bin_q;
  logic [MW-1:0]  s3_m_q;
  logic [MW-1:0]  s3_c_d [L], s3_c_q [L];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      s3_c_d[l] = cd_side.neg ? (cd_side.ml - cd_quot[l][MW-1:0])
                              : (cd_side.ml + cd_quot[l][MW-1:0]);
    end
  end

  // stage 4: pick the side of the triangle
  logic                s4_vld_q;
  mtw_pkg::wt_side_t   s4_side_d, s4_side_q;
  logic [MW-1:0]       s4_num_d, s4_num_q, s4_den_d, s4_den_q;
  logic                below, rise, fall;

  assign below = s3_m_q < s3_c_q[0];
  assign rise  = s3_m_q < s3_c_q[1];
  assign fall  = s3_m_q < s3_c_q[2];

  always_comb begin
    s4_side_d.idx_ok = s3_idx_q;
    s4_side_d.zero   = !s3_idx_q || !s3_bin_q || below || (!rise && !fall);
    // bin right on the centre gives the full weight
    s4_side_d.full   = !rise && (s3_m_q == s3_c_q[1]);
    if (rise) begin
      s4_num_d = s3_m_q - s3_c_q[0];
      s4_den_d = s3_c_q[1] - s3_c_q[0];
    end else begin
      s4_num_d = s3_c_q[2] - s3_m_q;
      s4_den_d = s3_c_q[2] - s3_c_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= cd_vld;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_idx_q  <= cd_side.idx_ok;
    s3_bin_q  <= cd_side.bin_ok;
    s3_m_q    <= cd_side.m;
    for (int l = 0; l < L; l++) begin
      s3_c_q[l] <= s3_c_d[l];
    end
    s4_side_q <= s4_side_d;
    s4_num_q  <= s4_num_d;
    s4_den_q  <= s4_den_d;
  end

  // fractional weight: numerator is below the denominator except at the peak
  logic               wd_vld;
  mtw_pkg::wt_side_t  wd_side;
  logic [0:0][15:0]   wd_quot;
  logic [0:0][MW:0]   wd_rem;
  logic [0:0][15:0]   wd_num;

  assign wd_rem[0] = {1'b0, s4_num_q};
  assign wd_num[0] = 16'd0;

  mtw_div #(
    .LANES (1),
    .RW    (MW + 1),
    .QW    (16),
    .STEPS (2),
    .SW    ($bits(mtw_pkg::wt_side_t))
  ) u_wt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .side_i  (s4_side_q),
    .den_i   ({1'b0, s4_den_q}),
    .rem_i   (wd_rem),
    .num_i   (wd_num),
    .valid_o (wd_vld),
    .side_o  (wd_side),
    .quot_o  (wd_quot)
  );

  // output register
  logic        res_vld_q, idx_valid_q;
  logic [16:0] weight_d, weight_q;

  assign weight_d = wd_side.zero ? 17'd0 :
                    wd_side.full ? 17'h10000 : {1'b0, wd_quot[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= wd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q    <= weight_d;
    idx_valid_q <= wd_side.idx_ok;
  end

  assign result_valid_o = res_vld_q;
  assign weight_o       = weight_q;
  assign index_valid_o  = idx_valid_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##32 result_valid_o)
    else $error("query transaction did not produce a result on time");

  a_bad_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !index_valid_o) |-> (weight_o == 17'd0))
    else $error("weight not forced to zero for an out of range filter");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (paddr[3:2] == mtw_pkg::REG_HIGH_FREQ)) |=>
      (high_freq_q == $past(pwdata[15:0])))
    else $error("high band edge register write lost");
`endif

endmodule

// ===== rtl/mtw_div.sv =====
// pipelined restoring divider, several lanes sharing one divisor
// depends on nothing; sideband travels alongside the valid bit
module mtw_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned RW    = 8,
  parameter int unsigned QW    = 16,
  parameter int unsigned STEPS = 2,
  parameter int unsigned SW    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [SW-1:0]                  side_i,
  input  logic [RW-1:0]                  den_i,
  input  logic [LANES-1:0][RW-1:0]       rem_i,
  input  logic [LANES-1:0][QW-1:0]       num_i,
  output logic                           valid_o,
  output logic [SW-1:0]                  side_o,
  output logic [LANES-1:0][QW-1:0]       quot_o
);

  localparam int unsigned NS = QW / STEPS;

  logic [NS-1:0]                vld_q;
  logic [SW-1:0]                side_q [NS];
  logic [RW-1:0]                den_q  [NS];
  logic [LANES-1:0][RW-1:0]     rem_q  [NS];
  logic [LANES-1:0][RW-1:0]     rem_d  [NS];
  logic [LANES-1:0][QW-1:0]     wrd_q  [NS];
  logic [LANES-1:0][QW-1:0]     wrd_d  [NS];

  // each step shifts one dividend bit into the remainder and one quotient bit out
  always_comb begin
    logic [RW-1:0] r;
    logic [RW-1:0] rs;
    logic [QW-1:0] w;
    logic [RW-1:0] d;
    for (int s = 0; s < NS; s++) begin
      d = (s == 0) ? den_i : den_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        r = (s == 0) ? rem_i[l] : rem_q[s-1][l];
        w = (s == 0) ? num_i[l] : wrd_q[s-1][l];
        for (int t = 0; t < STEPS; t++) begin
          rs = {r[RW-2:0], w[QW-1]};
          if (rs >= d) begin
            r = rs - d;
            w = {w[QW-2:0], 1'b1};
          end else begin
            r = rs;
            w = {w[QW-2:0], 1'b0};
          end
        end
        rem_d[s][l] = r;
        wrd_d[s][l] = w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      den_q[s]  <= (s == 0) ? den_i : den_q[s-1];
      rem_q[s]  <= rem_d[s];
      wrd_q[s]  <= wrd_d[s];
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign quot_o  = wrd_q[NS-1];

endmodule

// ===== rtl/mtw_mel.sv =====
// nine-stage hz to mel converter, lanes in lockstep
// depends on mtw_pkg for constants, the log2 table and the query type
module mtw_mel (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  mtw_pkg::query_t                               side_i,
  input  logic [mtw_pkg::MEL_LANES-1:0][mtw_pkg::FREQ_W-1:0] f_i,
  output logic                                          valid_o,
  output mtw_pkg::query_t                               side_o,
  output logic [mtw_pkg::MEL_LANES-1:0][mtw_pkg::MEL_W-1:0]  mel_o
);

  localparam int unsigned NSTG = 9;
  localparam int unsigned L    = mtw_pkg::MEL_LANES;

  logic [NSTG-1:0]  vld_q;
  mtw_pkg::query_t  side_q [NSTG];

  logic [34:0] y_d    [L], y_q  [L], y2_q [L], y3_q [L];
  logic [45:0] ph_d   [L], ph_q [L];
  logic [44:0] pl_d   [L], pl_q [L];
  logic [26:0] q0_d   [L], q0_q [L];
  logic [26:0] u_d    [L], u_q  [L], u4_q [L];
  logic [3:0]  e_d    [L], e_q  [L], e5_q [L];
  logic [16:0] t0_d   [L], t0_q [L];
  logic [16:0] t1_d   [L], t1_q [L];
  logic [11:0] r_d    [L], r_q  [L];
  logic [19:0] lg_d   [L], lg_q [L];
  logic [45:0] prod_d [L], prod_q [L];
  logic [19:0] mel_d  [L], mel_q [L];

  always_comb begin
    logic [36:0] x;
    logic [62:0] sum;
    logic [34:0] tq;
    logic [34:0] rm;
    logic [26:0] m;
    logic [12:0] diff;
    logic [24:0] ip;
    for (int l = 0; l < L; l++) begin
      x        = {1'b0, f_i[l]} + mtw_pkg::U_OFFSET;
      y_d[l]   = x[36:2];
      // reciprocal multiply split in two partial products
      ph_d[l]  = 46'(y_q[l][34:17]) * 46'(mtw_pkg::RECIP_175);
      pl_d[l]  = 45'(y_q[l][16:0]) * 45'(mtw_pkg::RECIP_175);
      sum      = {ph_q[l], 17'b0} + {18'b0, pl_q[l]};
      q0_d[l]  = sum[61:35];
      // estimate is at most one short
      tq       = 35'(q0_q[l]) * 35'(175);
      rm       = y3_q[l] - tq;
      u_d[l]   = q0_q[l] + 27'(rm >= 35'd175);
      e_d[l]   = 4'd0;
      for (int b = 0; b < 11; b++) begin
        if (u_q[l][16+b]) e_d[l] = 4'(b);
      end
      m        = u4_q[l] >> e_q[l];
      t0_d[l]  = mtw_pkg::log2_tab({1'b0, m[15:12]});
      t1_d[l]  = mtw_pkg::log2_tab({1'b0, m[15:12]} + 5'd1);
      r_d[l]   = m[11:0];
      diff     = 13'(t1_q[l] - t0_q[l]);
      ip       = 25'(diff) * 25'(r_q[l]);
      lg_d[l]  = {e5_q[l], 16'b0} + 20'(t0_q[l]) + 20'(ip[24:12]);
      prod_d[l] = 46'(lg_q[l]) * 46'(mtw_pkg::MEL_SCALE);
      mel_d[l] = (prod_q[l][45:24] > 22'(mtw_pkg::MEL_MAX)) ? mtw_pkg::MEL_MAX
                                                            : prod_q[l][43:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int s = 1; s < NSTG; s++) begin
      side_q[s] <= side_q[s-1];
    end
    for (int l = 0; l < L; l++) begin
      y_q[l]    <= y_d[l];
      ph_q[l]   <= ph_d[l];
      pl_q[l]   <= pl_d[l];
      y2_q[l]   <= y_q[l];
      q0_q[l]   <= q0_d[l];
      y3_q[l]   <= y2_q[l];
      u_q[l]    <= u_d[l];
      e_q[l]    <= e_d[l];
      u4_q[l]   <= u_q[l];
      e5_q[l]   <= e_q[l];
      t0_q[l]   <= t0_d[l];
      t1_q[l]   <= t1_d[l];
      r_q[l]    <= r_d[l];
      lg_q[l]   <= lg_d[l];
      prod_q[l] <= prod_d[l];
      mel_q[l]  <= mel_d[l];
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      mel_o[l] = mel_q[l];
    end
  end

`ifndef SYNTH
  // 1 + f/700 in Q16 is never below one
  a_u_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (u_q[0][26:16] != 11'd0) && (u_q[1][26:16] != 11'd0))
    else $error("mel lane lost normalisation after the divide by 700");
`endif

endmodule
